/* src/ric_pkg.sv */
// Shared types and constants for the radial interaction force pipeline.
package ric_pkg;

	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 17;
	localparam int SQD_W      = 62;
	localparam int DIST_W     = 31;
	localparam int REM_W      = 48;
	localparam int QUO_W      = 17;

	localparam logic [QUO_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;
	localparam logic [1:0] REG_STRENGTH = 2'd3;

	typedef struct packed {
		logic [15:0]        tag;
		logic               sx;
		logic               sy;
		logic [30:0]        ax;
		logic [30:0]        ay;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               in_rad;
		logic               dz;
	} ric_pay_t;

endpackage

/* src/ric_front.sv */
// Offset, magnitude, squaring and radius test stages.
module ric_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        in_tag,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic [30:0]        radius,
	output logic               out_valid,
	output ric_pkg::ric_pay_t  out_pay,
	output logic [61:0]        out_sqd
);
	import ric_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [15:0]        tag_s1, tag_s2, tag_s3;
	logic signed [31:0] vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3;
	logic signed [32:0] dx_s1, dy_s1;
	logic               sx_s2, sy_s2, far_s2, sx_s3, sy_s3, far_s3;
	logic [30:0]        ax_s2, ay_s2, ax_s3, ay_s3;
	logic [61:0]        dx2_s3, dy2_s3, r2_s3;
	logic [32:0]        magx, magy;
	logic [62:0]        sum;
	logic               in_rad;
	ric_pay_t           pay_s4;
	logic [61:0]        sqd_s4;

	assign magx   = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign magy   = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign sum    = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign in_rad = !far_s3 && (sum < {1'b0, r2_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {cx[31], cx} - {px[31], px};
			dy_s1  <= {cy[31], cy} - {py[31], py};
			tag_s1 <= in_tag;
			vx_s1  <= vx;
			vy_s1  <= vy;

			sx_s2  <= dx_s1[32];
			sy_s2  <= dy_s1[32];
			far_s2 <= (|magx[32:31]) || (|magy[32:31]);
			ax_s2  <= magx[30:0];
			ay_s2  <= magy[30:0];
			tag_s2 <= tag_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;

			dx2_s3 <= ax_s2 * ax_s2;
			dy2_s3 <= ay_s2 * ay_s2;
			r2_s3  <= radius * radius;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			far_s3 <= far_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			tag_s3 <= tag_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;

			pay_s4.tag    <= tag_s3;
			pay_s4.sx     <= sx_s3;
			pay_s4.sy     <= sy_s3;
			pay_s4.ax     <= ax_s3;
			pay_s4.ay     <= ay_s3;
			pay_s4.vx     <= vx_s3;
			pay_s4.vy     <= vy_s3;
			pay_s4.in_rad <= in_rad;
			pay_s4.dz     <= 1'b0;
			sqd_s4        <= in_rad ? sum[61:0] : '0;
		end
	end

	assign out_valid = valid_s4;
	assign out_pay   = pay_s4;
	assign out_sqd   = sqd_s4;

endmodule

/* src/ric_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ric_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ric_pkg::ric_pay_t in_pay,
	input  logic [61:0]       in_sqd,
	output logic              out_valid,
	output ric_pkg::ric_pay_t out_pay,
	output logic [30:0]       out_dist
);
	import ric_pkg::*;

	logic [SQD_W-1:0] rem_s  [1:SQRT_STEPS];
	logic [SQD_W-1:0] root_s [1:SQRT_STEPS];
	ric_pay_t         pay_s  [1:SQRT_STEPS];
	logic             valid_s [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SQD_W:0] BITV = (SQD_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [SQD_W-1:0] rem_i, root_i;
		ric_pay_t         pay_i;
		logic             valid_i;
		logic [SQD_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_src0
			assign rem_i   = in_sqd;
			assign root_i  = '0;
			assign pay_i   = in_pay;
			assign valid_i = in_valid;
		end else begin : g_srcn
			assign rem_i   = rem_s[k];
			assign root_i  = root_s[k];
			assign pay_i   = pay_s[k];
			assign valid_i = valid_s[k];
		end

		assign trial = {1'b0, root_i} + BITV;
		assign ge    = {1'b0, rem_i} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[k+1] <= pay_i;
				if (ge) begin
					rem_s[k+1]  <= rem_i - trial[SQD_W-1:0];
					root_s[k+1] <= (root_i >> 1) + BITV[SQD_W-1:0];
				end else begin
					rem_s[k+1]  <= rem_i;
					root_s[k+1] <= root_i >> 1;
				end
			end
		end
	end

	always_comb begin
		out_pay    = pay_s[SQRT_STEPS];
		out_pay.dz = (root_s[SQRT_STEPS] == '0);
	end

	assign out_valid = valid_s[SQRT_STEPS];
	assign out_dist  = root_s[SQRT_STEPS][DIST_W-1:0];

endmodule

/* src/ric_div.sv */
// Three-lane pipelined restoring divider for direction and weight quotients.
module ric_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ric_pkg::ric_pay_t in_pay,
	input  logic [30:0]       in_dist,
	input  logic [30:0]       radius,
	output logic              out_valid,
	output ric_pkg::ric_pay_t out_pay,
	output logic [16:0]       qx,
	output logic [16:0]       qy,
	output logic [16:0]       qw
);
	import ric_pkg::*;

	logic [REM_W-1:0]  rem_s [1:DIV_STEPS][0:2];
	logic [DIST_W-1:0] den_s [1:DIV_STEPS][0:2];
	logic [QUO_W-1:0]  quo_s [1:DIV_STEPS][0:2];
	ric_pay_t          pay_s [1:DIV_STEPS];
	logic              valid_s [1:DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic [REM_W-1:0]  rem_i [0:2];
		logic [DIST_W-1:0] den_i [0:2];
		logic [QUO_W-1:0]  quo_i [0:2];
		ric_pay_t          pay_i;
		logic              valid_i;

		if (k == 0) begin : g_src0
			assign rem_i[0] = REM_W'({in_pay.ax, 16'h0});
			assign rem_i[1] = REM_W'({in_pay.ay, 16'h0});
			assign rem_i[2] = REM_W'({in_dist, 16'h0});
			assign den_i[0] = in_dist;
			assign den_i[1] = in_dist;
			assign den_i[2] = radius;
			assign quo_i[0] = '0;
			assign quo_i[1] = '0;
			assign quo_i[2] = '0;
			assign pay_i    = in_pay;
			assign valid_i  = in_valid;
		end else begin : g_srcn
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = rem_s[k][l];
				assign den_i[l] = den_s[k][l];
				assign quo_i[l] = quo_s[k][l];
			end
			assign pay_i   = pay_s[k];
			assign valid_i = valid_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_i;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_calc
			logic [REM_W-1:0] trial;
			logic             ge;

			assign trial = REM_W'(den_i[l]) << SH;
			assign ge    = rem_i[l] >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? rem_i[l] - trial : rem_i[l];
					den_s[k+1][l] <= den_i[l];
					quo_s[k+1][l] <= {quo_i[l][QUO_W-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[k+1] <= pay_i;
			end
		end
	end

	assign out_valid = valid_s[DIV_STEPS];
	assign out_pay   = pay_s[DIV_STEPS];
	assign qx        = quo_s[DIV_STEPS][0];
	assign qy        = quo_s[DIV_STEPS][1];
	assign qw        = quo_s[DIV_STEPS][2];

endmodule

/* src/ric_back.sv */
// Strength and weight multiply stages with saturation and the output register.
module ric_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ric_pkg::ric_pay_t  in_pay,
	input  logic [16:0]        qx,
	input  logic [16:0]        qy,
	input  logic [16:0]        qw,
	input  logic signed [31:0] strength,
	output logic               out_valid,
	output logic [15:0]        out_tag,
	output logic [31:0]        fx,
	output logic [31:0]        fy,
	output logic               in_range
);
	import ric_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [15:0]        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic               ins_s1, ins_s2, ins_s3, ins_s4, ins_s5;
	logic signed [31:0] vx_s1, vy_s1, vx_s2, vy_s2;
	logic signed [17:0] dirx_s1, diry_s1;
	logic [16:0]        wt_s1, wt_s2, wt_s3;
	logic signed [49:0] px_s2, py_s2;
	logic signed [34:0] tx_s3, ty_s3;
	logic signed [52:0] mx_s4, my_s4;
	logic [31:0]        fx_s5, fy_s5;
	logic signed [17:0] dirx, diry;
	logic signed [49:0] shx, shy;
	logic signed [52:0] fwx, fwy;

	function automatic logic [31:0] sat32(input logic signed [52:0] v);
		logic [31:0] r;
		begin
			if (v > $signed(53'h0_0000_7FFF_FFFF)) begin
				r = 32'h7FFF_FFFF;
			end else if (v < -$signed(53'h0_0000_8000_0000)) begin
				r = 32'h8000_0000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

	assign dirx = in_pay.dz ? '0 : (in_pay.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
	assign diry = in_pay.dz ? '0 : (in_pay.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
	assign shx  = px_s2 >>> 16;
	assign shy  = py_s2 >>> 16;
	assign fwx  = mx_s4 >>> 16;
	assign fwy  = my_s4 >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dirx_s1 <= dirx;
			diry_s1 <= diry;
			wt_s1   <= ONE_Q16 - qw;
			vx_s1   <= in_pay.vx;
			vy_s1   <= in_pay.vy;
			tag_s1  <= in_pay.tag;
			ins_s1  <= in_pay.in_rad;

			px_s2  <= dirx_s1 * strength;
			py_s2  <= diry_s1 * strength;
			wt_s2  <= wt_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			tag_s2 <= tag_s1;
			ins_s2 <= ins_s1;

			tx_s3  <= shx[34:0] - {{3{vx_s2[31]}}, vx_s2};
			ty_s3  <= shy[34:0] - {{3{vy_s2[31]}}, vy_s2};
			wt_s3  <= wt_s2;
			tag_s3 <= tag_s2;
			ins_s3 <= ins_s2;

			mx_s4  <= tx_s3 * $signed({1'b0, wt_s3});
			my_s4  <= ty_s3 * $signed({1'b0, wt_s3});
			tag_s4 <= tag_s3;
			ins_s4 <= ins_s3;

			fx_s5  <= ins_s4 ? sat32(fwx) : '0;
			fy_s5  <= ins_s4 ? sat32(fwy) : '0;
			tag_s5 <= tag_s4;
			ins_s5 <= ins_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_tag   = tag_s5;
	assign fx        = fx_s5;
	assign fy        = fy_s5;
	assign in_range  = ins_s5;

endmodule

/* src/radial_interaction_force.sv */
// An accepted request passes through the front, root, divide and back stages to its result.
// Throughput: one request per cycle; the whole pipeline advances together whenever the
// output register is empty or its result is being taken.
// Reset: arst_n clears all valid bits and the four configuration registers to zero;
// a zero radius gives zero force and in_range low for every particle.
module radial_interaction_force (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // particle_tag, particle_x, particle_y, velocity_x, velocity_y
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,  // result_tag, force_x, force_y
	output logic [0:0]   m_axis_tuser,  // in_range
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_addr,
	input  logic [31:0]  cfg_data
);
	import ric_pkg::*;

	logic signed [31:0] center_x_q, center_y_q, strength_q;
	logic [30:0]        radius_q;
	logic               en;
	logic               fr_valid, sq_valid, dv_valid;
	ric_pay_t           fr_pay, sq_pay, dv_pay;
	logic [61:0]        fr_sqd;
	logic [30:0]        sq_dist;
	logic [16:0]        qx, qy, qw;
	logic [15:0]        out_tag;
	logic [31:0]        fx, fy;
	logic               in_range;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			strength_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_RADIUS:   radius_q   <= cfg_data[30:0];
				REG_STRENGTH: strength_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ric_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_tag   (s_axis_tdata[15:0]),
		.px       (s_axis_tdata[47:16]),
		.py       (s_axis_tdata[79:48]),
		.vx       (s_axis_tdata[111:80]),
		.vy       (s_axis_tdata[143:112]),
		.cx       (center_x_q),
		.cy       (center_y_q),
		.radius   (radius_q),
		.out_valid(fr_valid),
		.out_pay  (fr_pay),
		.out_sqd  (fr_sqd)
	);

	ric_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_pay   (fr_pay),
		.in_sqd   (fr_sqd),
		.out_valid(sq_valid),
		.out_pay  (sq_pay),
		.out_dist (sq_dist)
	);

	ric_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_pay   (sq_pay),
		.in_dist  (sq_dist),
		.radius   (radius_q),
		.out_valid(dv_valid),
		.out_pay  (dv_pay),
		.qx       (qx),
		.qy       (qy),
		.qw       (qw)
	);

	ric_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dv_valid),
		.in_pay   (dv_pay),
		.qx       (qx),
		.qy       (qy),
		.qw       (qw),
		.strength (strength_q),
		.out_valid(m_axis_tvalid),
		.out_tag  (out_tag),
		.fx       (fx),
		.fy       (fy),
		.in_range (in_range)
	);

	assign m_axis_tdata = {fy, fx, out_tag};
	assign m_axis_tuser = in_range;

`ifndef SYNTHESIS
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[79:16] == '0)
		else $error("force is nonzero for a particle outside the radius");

	a_zero_root_at_center: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_pay.in_rad && sq_pay.dz |-> sq_pay.ax == '0 && sq_pay.ay == '0)
		else $error("zero distance reported for a particle away from the center");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_pay.in_rad && !dv_pay.dz |-> qx <= ONE_Q16 && qy <= ONE_Q16)
		else $error("direction component exceeds one");
`endif

endmodule

/* test/radial_force_checker.sv */
// Checker that predicts and compares the radial interaction force results.
`timescale 1ns / 1ps
module radial_force_checker (
	input  logic         clk,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [79:0]  m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_addr,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending
);
	import ric_pkg::*;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               inr;
	} force_t;

	longint    center_x = 0;
	longint    center_y = 0;
	bit [63:0] radius   = 0;
	longint    strength = 0;
	force_t    expected_forces[$];

	initial errors = 0;
	assign pending = expected_forces.size();

	function automatic bit [63:0] root_floor(bit [63:0] v);
		bit [63:0] res = 0;
		bit [63:0] b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_part(longint off, bit [63:0] dlen);
		bit [63:0] mag = off < 0 ? -off : off;
		bit [63:0] q;
		if (dlen == 0) return 0;
		q = (mag << 16) / dlen;
		return off < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] axis_push(longint dir, longint vel, longint weight);
		longint t = ((dir * strength) >>> 16) - vel;
		longint f = (t * weight) >>> 16;
		if (f > 64'sd2147483647) return 32'sh7fffffff;
		if (f < -64'sd2147483648) return 32'sh80000000;
		return f[31:0];
	endfunction

	function automatic force_t predict_force(logic [143:0] d);
		force_t r;
		longint dx = center_x - longint'($signed(d[47:16]));
		longint dy = center_y - longint'($signed(d[79:48]));
		bit [63:0] ax = dx < 0 ? -dx : dx;
		bit [63:0] ay = dy < 0 ? -dy : dy;
		bit [64:0] s = {1'b0, ax * ax} + {1'b0, ay * ay};
		bit [63:0] sqd = s[64] ? '1 : s[63:0];
		bit [63:0] dlen;
		longint weight;
		r.tag = d[15:0];
		r.fx = 0;
		r.fy = 0;
		r.inr = sqd < radius * radius;
		if (r.inr) begin
			dlen = root_floor(sqd);
			weight = 65536 - longint'((dlen << 16) / radius);
			r.fx = axis_push(unit_part(dx, dlen), $signed(d[111:80]), weight);
			r.fy = axis_push(unit_part(dy, dlen), $signed(d[143:112]), weight);
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin
		force_t want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_CENTER_X: center_x = $signed(cfg_data);
				REG_CENTER_Y: center_y = $signed(cfg_data);
				REG_RADIUS:   radius = {33'd0, cfg_data[30:0]};
				REG_STRENGTH: strength = $signed(cfg_data);
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready)
			expected_forces = {expected_forces, predict_force(s_axis_tdata)};
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_forces.size() == 0) begin
				report("unexpected result", 64'(m_axis_tdata), 64'(0));
			end else begin
				want = expected_forces.pop_front();
				if (m_axis_tdata[15:0] != want.tag)
					report("result_tag", 64'(m_axis_tdata[15:0]), 64'(want.tag));
				if (m_axis_tdata[47:16] != want.fx)
					report("force_x", 64'(m_axis_tdata[47:16]), 64'(want.fx));
				if (m_axis_tdata[79:48] != want.fy)
					report("force_y", 64'(m_axis_tdata[79:48]), 64'(want.fy));
				if (m_axis_tuser[0] != want.inr)
					report("in_range", 64'(m_axis_tuser[0]), 64'(want.inr));
			end
		end
	end

endmodule

/* test/testbench.sv */
// Top level that drives particles and configuration into the force pipeline.
`timescale 1ns / 1ps
module testbench;
	import ric_pkg::*;

	localparam int LIMIT = 600000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [79:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [1:0]   cfg_addr = 0;
	logic [31:0]  cfg_data = 0;
	int           errors;
	int           pending;
	int           tx_idle = 0;
	int           rx_idle = 0;
	bit           hold_go = 0;
	int           cycles = 0;
	longint       cur_cx = 0;
	longint       cur_cy = 0;
	longint       cur_r = 0;

	always #1 clk = ~clk;

	radial_interaction_force dut (.*);

	radial_force_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= rx_idle;
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] addr, logic [31:0] data);
		cfg_addr <= addr;
		cfg_data <= data;
		cfg_valid <= 1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		if (addr == REG_CENTER_X) cur_cx = $signed(data);
		if (addr == REG_CENTER_Y) cur_cy = $signed(data);
		if (addr == REG_RADIUS) cur_r = data[30:0];
	endtask

	task automatic set_force(logic [31:0] cx, logic [31:0] cy, logic [31:0] r, logic [31:0] st);
		wait_drained();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIUS, r);
		write_reg(REG_STRENGTH, st);
		cfg_valid <= 0;
	endtask

	task automatic send_particle(logic [15:0] tag, logic [31:0] px, logic [31:0] py,
			logic [31:0] vx, logic [31:0] vy);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tdata <= {vy, vx, py, px, tag};
		s_axis_tvalid <= 1;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_axis(longint c);
		longint span = cur_r + cur_r / 8 + 2;
		longint off = longint'({$urandom, $urandom}) % span;
		return 32'(c + off);
	endfunction

	task automatic random_particle();
		logic [31:0] px, py, vx, vy;
		vx = $urandom;
		vy = $urandom;
		if ($urandom_range(3) == 0) begin
			vx = $signed(vx) >>> $urandom_range(31);
			vy = $signed(vy) >>> $urandom_range(31);
		end
		if ($urandom_range(9) < 7) begin
			px = near_axis(cur_cx);
			py = near_axis(cur_cy);
		end else begin
			px = $urandom;
			py = $urandom;
		end
		send_particle(16'($urandom), px, py, vx, vy);
	endtask

	task automatic directed_particles();
		longint r;
		r = cur_r;
		send_particle(16'h0000, 32'(cur_cx), 32'(cur_cy), 32'h0001_0000, 32'hffff_0000);
		send_particle(16'hffff, 32'(cur_cx), 32'(cur_cy), 32'h8000_0000, 32'h7fff_ffff);
		send_particle(16'h1234, 32'(cur_cx - r), 32'(cur_cy), 0, 0);
		send_particle(16'h1235, 32'(cur_cx - r + 1), 32'(cur_cy), 0, 0);
		send_particle(16'h1236, 32'(cur_cx), 32'(cur_cy + r - 1), 32'h7fff_ffff, 32'h8000_0000);
		send_particle(16'h1237, 32'(cur_cx + r / 2), 32'(cur_cy - r / 3), 0, 32'h0000_8000);
		send_particle(16'h8000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send_particle(16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_particle(16'h0001, 32'(cur_cx + 1), 32'(cur_cy - 1), 32'hffff_ffff, 1);
		send_particle(16'h5a5a, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 32'h8765_4321);
	endtask

	initial begin
		logic [31:0] settings[8][4];
		settings = '{
			'{32'h0000_0000, 32'h0000_0000, 32'h000a_0000, 32'h0002_0000},
			'{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
			'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
			'{32'h0010_0000, 32'hfff0_0000, 32'h0000_0001, 32'hffff_0000},
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
			'{32'hfff8_0000, 32'h0003_8000, 32'h0040_0000, 32'hfffe_8000},
			'{$urandom, $urandom, $urandom_range(32'h7fff_ffff), $urandom},
			'{$urandom, $urandom, $urandom_range(32'h00ff_ffff), $urandom}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_particles();
		for (int ph = 0; ph < 9; ph++) begin
			tx_idle = ph < 3 ? 33 : ph < 6 ? 78 : 0;
			rx_idle = ph < 3 ? 78 : ph < 6 ? 33 : 0;
			s_axis_tvalid <= 0;
			set_force(settings[ph % 8][0], settings[ph % 8][1], settings[ph % 8][2],
				settings[ph % 8][3]);
			if (ph < 3) directed_particles();
			if (ph == 7) hold_go = 1;
			repeat (123) random_particle();
		end
		s_axis_tvalid <= 0;
		wait_drained();
		repeat (70) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
